/* rtl/ltte_pkg.sv */
// Package for the line tokenizer with tab expansion.
// Holds the channel payload types, token kinds, register indexes and reset values.
// No dependencies.
`default_nettype none

package ltte_pkg;

   localparam int OFFSET_W = 12;
   localparam int COUNT_W  = 13;
   localparam int COLUMN_W = 16;

   typedef enum logic [1:0] {
      KIND_WORD  = 2'd0,
      KIND_DELIM = 2'd1,
      KIND_SPACE = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      REG_SHOW_WS   = 2'd0,
      REG_TAB_SPACE = 2'd1,
      REG_MAP_LOW   = 2'd2,
      REG_MAP_HIGH  = 2'd3
   } reg_index_type;

   localparam logic [15:0] CHAR_TAB   = 16'd9;
   localparam logic [15:0] CHAR_CR    = 16'd13;
   localparam logic [15:0] CHAR_SPACE = 16'd32;

   localparam logic [4:0]  TAB_SPACING_RESET = 5'd4;
   localparam logic [4:0]  TAB_SPACING_MAX   = 5'd16;
   localparam logic [63:0] MAP_LOW_RESET     = 64'hFC00_FFE3_0000_2600;
   localparam logic [63:0] MAP_HIGH_RESET    = 64'h3800_0000_7800_0001;

   typedef struct packed {
      logic [15:0] char_code;
      logic        last_char;
   } req_type;

   typedef struct packed {
      logic [1:0]          token_kind;
      logic [OFFSET_W-1:0] start_offset;
      logic [COLUMN_W-1:0] start_column;
      logic [COUNT_W-1:0]  char_count;
      logic [COLUMN_W-1:0] display_width;
      logic                line_done;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/line_tokenizer_tab_expand.sv */
// Line tokenizer with tab expansion: splits a character stream into word,
// delimiter and whitespace tokens with offsets, columns and display widths.
// Depends on ltte_pkg.
`default_nettype none

//  Channel   Direction  Handshake           Contents
//  req_      in         valid / stall       one character and a last-of-line flag
//  rsp_      out        valid / stall       one finished token
//  csr_      in/out     APB-style, 64 bits  show_whitespace, tab_spacing, delimiter maps
//
//  A character is taken into an input register and classified from there; once the
//  queue has room, this updates the token state and writes up to two tokens into a
//  four-entry result queue. One character per cycle is sustained while tokens are drained;
//  a character that ends a token on the last position of a line yields two tokens,
//  which leave the result channel one after the other. The input register holds its
//  character while the queue has fewer than two free entries. Reset is synchronous
//  and clears the line state, the queue and the registers to their reset values.

module line_tokenizer_tab_expand
   import ltte_pkg::*;
#(
   parameter int LINE_MAX    = 4096,
   parameter int COLUMN_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_payload,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic [63:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int IDX_W = $clog2(LINE_MAX);
   localparam int CNT_W = IDX_W + 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = QPTR_W + 1;
   localparam logic [IDX_W-1:0]       IDX_LAST = IDX_W'(LINE_MAX - 1);
   localparam logic [CNT_W-1:0]       CNT_MAX  = CNT_W'(LINE_MAX);
   localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};
   localparam logic [COLUMN_W-1:0]    SAT_MAX  = {COLUMN_W{1'b1}};

   // Configuration registers.
   logic        show_ws_ff;
   logic [4:0]  tab_spacing_ff;
   logic [63:0] map_low_ff;
   logic [63:0] map_high_ff;

   // Input register.
   logic    in_vld_ff, in_vld_in;
   req_type in_ff;

   // Line and token state.
   logic                   token_open_ff, token_open_in;
   logic                   open_closed_ff, open_closed_in;
   kind_type               open_kind_ff, open_kind_in;
   logic [IDX_W-1:0]       open_offset_ff, open_offset_in;
   logic [COLUMN_BITS-1:0] open_column_ff, open_column_in;
   logic [CNT_W-1:0]       open_count_ff, open_count_in;
   logic [COLUMN_W-1:0]    open_width_ff, open_width_in;
   logic [IDX_W-1:0]       char_index_ff, char_index_in;
   logic [COLUMN_BITS-1:0] column_ff, column_in;
   logic [3:0]             tab_phase_ff, tab_phase_in;

   // Result queue.
   rsp_type           queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] qcount_ff, qcount_in;

   logic              accept, process, pop, csr_write;
   logic [127:0]      delim_map;
   logic [15:0]       ch;
   logic              is_space, is_delim, is_tab;
   kind_type          ch_kind;
   logic [4:0]        spacing, phase_ext, phase_inc, adv;
   logic              extend, skip, emit_old, emit_new;
   logic [COLUMN_W:0] width_sum;
   logic [COLUMN_BITS:0] column_sum;
   rsp_type           res_old, res_new, slot0;
   logic [1:0]        push_n;

   function automatic logic [COLUMN_W-1:0] sat_column(input logic [COLUMN_BITS-1:0] v);
      logic [32:0] wide;
      wide = 33'(v);
      return (wide > 33'(SAT_MAX)) ? SAT_MAX : wide[COLUMN_W-1:0];
   endfunction

   function automatic rsp_type make_token(
      input kind_type               kind,
      input logic [IDX_W-1:0]       offset,
      input logic [COLUMN_BITS-1:0] column,
      input logic [CNT_W-1:0]       count,
      input logic [COLUMN_W-1:0]    width,
      input logic                   done
   );
      rsp_type r;
      r.token_kind    = kind;
      r.start_offset  = OFFSET_W'(32'(offset));
      r.start_column  = sat_column(column);
      r.char_count    = COUNT_W'(32'(count));
      r.display_width = width;
      r.line_done     = done;
      return r;
   endfunction

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (reg_index_type'(csr_paddr[4:3]))
         REG_SHOW_WS:   csr_prdata = {63'd0, show_ws_ff};
         REG_TAB_SPACE: csr_prdata = {59'd0, tab_spacing_ff};
         REG_MAP_LOW:   csr_prdata = map_low_ff;
         REG_MAP_HIGH:  csr_prdata = map_high_ff;
         default:       csr_prdata = 64'd0;
      endcase
   end

   // Handshakes.
   assign process   = in_vld_ff && (qcount_ff <= QCNT_W'(QUEUE_DEPTH - 2));
   assign req_stall = in_vld_ff && !process;
   assign accept    = req_valid && !req_stall;
   assign in_vld_in = accept || (in_vld_ff && !process);
   assign rsp_valid = (qcount_ff != '0);
   assign rsp_payload = queue_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   // Character classification and column advance.
   assign delim_map = {map_high_ff, map_low_ff};
   assign ch        = in_ff.char_code;
   assign is_tab    = (ch == CHAR_TAB);
   assign is_space  = (ch == CHAR_SPACE) || ((ch >= CHAR_TAB) && (ch <= CHAR_CR));
   assign is_delim  = !is_space && (ch[15:7] == 9'd0) && delim_map[ch[6:0]];
   assign ch_kind   = is_space ? KIND_SPACE : (is_delim ? KIND_DELIM : KIND_WORD);

   assign spacing   = (tab_spacing_ff == 5'd0) ? 5'd1 :
                      ((tab_spacing_ff > TAB_SPACING_MAX) ? TAB_SPACING_MAX : tab_spacing_ff);
   assign phase_ext = {1'b0, tab_phase_ff};
   assign phase_inc = phase_ext + 5'd1;
   assign adv       = !is_tab ? 5'd1 :
                      ((phase_ext < spacing) ? (spacing - phase_ext) : spacing);

   assign extend   = token_open_ff && !open_closed_ff && (ch_kind != KIND_DELIM) &&
                     (ch_kind == open_kind_ff);
   assign skip     = !extend && (ch_kind == KIND_SPACE) && !show_ws_ff;
   assign emit_old = !extend && !skip && token_open_ff;

   assign width_sum  = {1'b0, open_width_ff} + (COLUMN_W + 1)'(adv);
   assign column_sum = {1'b0, column_ff} + (COLUMN_BITS + 1)'(adv);

   always_comb begin
      token_open_in  = token_open_ff;
      open_closed_in = open_closed_ff;
      open_kind_in   = open_kind_ff;
      open_offset_in = open_offset_ff;
      open_column_in = open_column_ff;
      open_count_in  = open_count_ff;
      open_width_in  = open_width_ff;
      if (extend) begin
         if (open_count_ff < CNT_MAX) begin
            open_count_in = open_count_ff + CNT_W'(1);
         end
         open_width_in = width_sum[COLUMN_W] ? SAT_MAX : width_sum[COLUMN_W-1:0];
      end else if (skip) begin
         open_closed_in = 1'b1;
      end else begin
         token_open_in  = 1'b1;
         open_closed_in = (ch_kind == KIND_DELIM);
         open_kind_in   = ch_kind;
         open_offset_in = char_index_ff;
         open_column_in = column_ff;
         open_count_in  = CNT_W'(1);
         open_width_in  = COLUMN_W'(adv);
      end
   end

   assign emit_new = in_ff.last_char && token_open_in;
   assign res_old  = make_token(open_kind_ff, open_offset_ff, open_column_ff,
                                open_count_ff, open_width_ff, 1'b0);
   assign res_new  = make_token(open_kind_in, open_offset_in, open_column_in,
                                open_count_in, open_width_in, 1'b1);
   assign slot0    = emit_old ? res_old : res_new;
   assign push_n   = process ? ({1'b0, emit_old} + {1'b0, emit_new}) : 2'd0;

   always_comb begin
      if (is_tab) begin
         tab_phase_in = 4'd0;
      end else begin
         tab_phase_in = (phase_inc >= spacing) ? 4'd0 : phase_inc[3:0];
      end
      column_in     = (column_sum > {1'b0, COL_MAX}) ? COL_MAX : column_sum[COLUMN_BITS-1:0];
      char_index_in = (char_index_ff < IDX_LAST) ? (char_index_ff + IDX_W'(1)) : char_index_ff;
   end

   assign wr_ptr_in = wr_ptr_ff + QPTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
   assign qcount_in = qcount_ff + QCNT_W'(push_n) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         show_ws_ff     <= 1'b0;
         tab_spacing_ff <= TAB_SPACING_RESET;
         map_low_ff     <= MAP_LOW_RESET;
         map_high_ff    <= MAP_HIGH_RESET;
         in_vld_ff      <= 1'b0;
         token_open_ff  <= 1'b0;
         open_closed_ff <= 1'b0;
         open_kind_ff   <= KIND_WORD;
         open_offset_ff <= '0;
         open_column_ff <= '0;
         open_count_ff  <= '0;
         open_width_ff  <= '0;
         char_index_ff  <= '0;
         column_ff      <= '0;
         tab_phase_ff   <= '0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         qcount_ff      <= '0;
      end else begin
         if (csr_write) begin
            case (reg_index_type'(csr_paddr[4:3]))
               REG_SHOW_WS:   show_ws_ff     <= csr_pwdata[0];
               REG_TAB_SPACE: tab_spacing_ff <= csr_pwdata[4:0];
               REG_MAP_LOW:   map_low_ff     <= csr_pwdata;
               REG_MAP_HIGH:  map_high_ff    <= csr_pwdata;
               default:       ;
            endcase
         end
         in_vld_ff <= in_vld_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         qcount_ff <= qcount_in;
         if (process) begin
            if (in_ff.last_char) begin
               // The line ends here: its state starts over for the next line.
               token_open_ff  <= 1'b0;
               open_closed_ff <= 1'b0;
               open_kind_ff   <= KIND_WORD;
               open_offset_ff <= '0;
               open_column_ff <= '0;
               open_count_ff  <= '0;
               open_width_ff  <= '0;
               char_index_ff  <= '0;
               column_ff      <= '0;
               tab_phase_ff   <= '0;
            end else begin
               token_open_ff  <= token_open_in;
               open_closed_ff <= open_closed_in;
               open_kind_ff   <= open_kind_in;
               open_offset_ff <= open_offset_in;
               open_column_ff <= open_column_in;
               open_count_ff  <= open_count_in;
               open_width_ff  <= open_width_in;
               char_index_ff  <= char_index_in;
               column_ff      <= column_in;
               tab_phase_ff   <= tab_phase_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_payload;
      end
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= slot0;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_ff + QPTR_W'(1)] <= res_new;
      end
   end

   // The queue never holds more entries than it has.
   assert property (@(posedge clock) disable iff (reset)
      qcount_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   // An open token always holds at least one character.
   assert property (@(posedge clock) disable iff (reset)
      token_open_ff |-> (open_count_ff != '0))
      else $error("open token with no characters");

   // Finishing a line leaves no token open and the column back at zero.
   assert property (@(posedge clock) disable iff (reset)
      (process && in_ff.last_char) |=> (!token_open_ff && (column_ff == '0)))
      else $error("line state not cleared at end of line");

   // A character is never taken while the register still holds an unprocessed one.
   assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !process) |-> !accept)
      else $error("input register overwritten");

endmodule

`default_nettype wire
